// ===== rtl/lpmb_pkg.sv =====
// ----------------------------------------------------------------------------
// lpmb_pkg
// Shared types and codes for the length-prefixed message buffer.
// ----------------------------------------------------------------------------
package lpmb_pkg;

  localparam int unsigned OFS_W     = 13;
  localparam int unsigned LEN_W     = 12;
  localparam int unsigned PFX_BYTES = 4;
  localparam int unsigned CNT_W     = 3;

  typedef logic [OFS_W-1:0] ofs_t;

  localparam ofs_t CAP_RESET = 13'd4096;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_UNBOUND = 3'd1,
    ST_BADLEN  = 3'd2,
    ST_DROPPED = 3'd3,
    ST_EMPTY   = 3'd4,
    ST_CORRUPT = 3'd5,
    ST_DISCARD = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    CMD_PUSH_START = 2'd0,
    CMD_PUSH_DATA  = 2'd1,
    CMD_POP        = 2'd2,
    CMD_NONE       = 2'd3
  } cmd_t;

  localparam logic REG_ARENA_BOUND = 1'b0;
  localparam logic REG_CAPACITY    = 1'b1;

  typedef enum logic [7:0] {
    S_IDLE      = 8'b0000_0001,
    S_EXEC      = 8'b0000_0010,
    S_WR_PFX    = 8'b0000_0100,
    S_RD_PFX    = 8'b0000_1000,
    S_POP_CHK   = 8'b0001_0000,
    S_RD_BYTE   = 8'b0010_0000,
    S_BYTE_WAIT = 8'b0100_0000,
    S_DONE      = 8'b1000_0000
  } state_t;

endpackage

// ===== rtl/length_prefixed_message_buffer_core.sv =====
// ----------------------------------------------------------------------------
// length_prefixed_message_buffer_core
// Byte message queue: each message is stored as a 4-byte little-endian length
// followed by its bytes; pops hand out one byte per transfer.
//
//  channel   direction  tdata (low bit up)                      tuser / tlast
//  s_*       in         push_length[15:0] data_byte[23:16]       cmd[1:0]
//  m_*       out        out_byte[7:0] message_length[19:8]       status[2:0]
//                       drop_count[51:20]                        last_byte
//  apb       in/out     0x0 arena_bound, 0x4 capacity
//
// a push start makes four prefix writes through the single store port; the first
// pop of a message makes four prefix reads through the registered store read
// port, followed by the byte read.
// reset clears all queue state at once; the store has no clearing pass.
// a finished result waits in the output register; the next item is accepted
// meanwhile and the sequencer holds in its final step until the register frees.
// ----------------------------------------------------------------------------
module length_prefixed_message_buffer_core #(
  parameter int unsigned STORE_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // push_length[15:0], data_byte[23:16]
  input  logic [1:0]  s_tuser,   // cmd[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // out_byte[7:0], message_length[19:8], drop_count[51:20]
  output logic [2:0]  m_tuser,   // status[2:0]
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned AW = $clog2(STORE_BYTES);

  lpmb_pkg::state_t state, state_next;

  logic                 arena_bound, arena_bound_next;
  lpmb_pkg::ofs_t       capacity, capacity_next;
  lpmb_pkg::ofs_t       write_offset, write_offset_next;
  lpmb_pkg::ofs_t       read_offset, read_offset_next;
  logic [31:0]          dropped_pushes, dropped_pushes_next;
  logic                 push_active, push_active_next;
  lpmb_pkg::ofs_t       push_remaining, push_remaining_next;
  lpmb_pkg::ofs_t       push_cursor, push_cursor_next;
  logic [lpmb_pkg::LEN_W-1:0] push_total, push_total_next;
  logic                 pop_active, pop_active_next;
  lpmb_pkg::ofs_t       pop_remaining, pop_remaining_next;
  lpmb_pkg::ofs_t       pop_cursor, pop_cursor_next;
  logic [lpmb_pkg::LEN_W-1:0] pop_total, pop_total_next;

  lpmb_pkg::cmd_t       cmd_r;
  logic [15:0]          len_r;
  logic [7:0]           byte_r;
  lpmb_pkg::ofs_t       pfx_base, pfx_base_next;
  logic [lpmb_pkg::CNT_W-1:0] cnt, cnt_next;
  logic [31:0]          plen, plen_next;

  lpmb_pkg::status_t    res_status, res_status_next;
  logic [7:0]           res_byte, res_byte_next;
  logic                 res_last, res_last_next;
  logic [lpmb_pkg::LEN_W-1:0] res_mlen, res_mlen_next;

  logic                 m_tvalid_next;
  lpmb_pkg::status_t    out_status;
  logic [7:0]           out_byte;
  logic                 out_last;
  logic [lpmb_pkg::LEN_W-1:0] out_mlen;
  logic [31:0]          out_drop;

  logic                 store_we;
  lpmb_pkg::ofs_t       store_addr;
  logic [7:0]           store_wdata;
  logic [7:0]           store_rdata;
  logic                 store_in_range;

  logic                 cfg_we;
  lpmb_pkg::ofs_t       cap_eff;
  lpmb_pkg::ofs_t       max_len;
  logic [16:0]          needed;
  lpmb_pkg::ofs_t       room;
  lpmb_pkg::ofs_t       avail;
  lpmb_pkg::ofs_t       push_cursor_inc;
  lpmb_pkg::ofs_t       pop_cursor_inc;
  lpmb_pkg::ofs_t       pfx_addr;
  logic                 no_room;

  assign pready   = 1'b1;
  assign cfg_we   = psel & penable & pwrite & pready;
  assign prdata   = (paddr[2] == lpmb_pkg::REG_CAPACITY) ? {19'd0, capacity}
                                                         : {31'd0, arena_bound};
  assign s_tready = (state == lpmb_pkg::S_IDLE);

  assign m_tdata  = {4'd0, out_drop, out_mlen, out_byte};
  assign m_tuser  = out_status;
  assign m_tlast  = out_last;

  assign cap_eff  = (32'(capacity) > STORE_BYTES) ? lpmb_pkg::ofs_t'(STORE_BYTES) : capacity;
  assign max_len  = (cap_eff > lpmb_pkg::ofs_t'(lpmb_pkg::PFX_BYTES))
                    ? cap_eff - lpmb_pkg::ofs_t'(lpmb_pkg::PFX_BYTES) : '0;
  assign needed   = {1'b0, len_r} + 17'(lpmb_pkg::PFX_BYTES);
  assign room     = cap_eff - write_offset;
  assign avail    = write_offset - read_offset - lpmb_pkg::ofs_t'(lpmb_pkg::PFX_BYTES);
  assign no_room  = (write_offset > cap_eff) || (read_offset > cap_eff) ||
                    (needed > {4'd0, room});
  assign push_cursor_inc = push_cursor + lpmb_pkg::ofs_t'(1);
  assign pop_cursor_inc  = pop_cursor + lpmb_pkg::ofs_t'(1);
  assign pfx_addr        = pfx_base + lpmb_pkg::ofs_t'(cnt);
  assign store_in_range  = 32'(store_addr) < STORE_BYTES;

  always_comb begin
    state_next          = state;
    arena_bound_next    = arena_bound;
    capacity_next       = capacity;
    write_offset_next   = write_offset;
    read_offset_next    = read_offset;
    dropped_pushes_next = dropped_pushes;
    push_active_next    = push_active;
    push_remaining_next = push_remaining;
    push_cursor_next    = push_cursor;
    push_total_next     = push_total;
    pop_active_next     = pop_active;
    pop_remaining_next  = pop_remaining;
    pop_cursor_next     = pop_cursor;
    pop_total_next      = pop_total;
    pfx_base_next       = pfx_base;
    cnt_next            = cnt;
    plen_next           = plen;
    res_status_next     = res_status;
    res_byte_next       = res_byte;
    res_last_next       = res_last;
    res_mlen_next       = res_mlen;
    store_we            = 1'b0;
    store_addr          = pfx_addr;
    store_wdata         = byte_r;
    m_tvalid_next       = m_tvalid & ~m_tready;

    case (state)
      lpmb_pkg::S_IDLE: begin
        if (s_tvalid) begin
          state_next = lpmb_pkg::S_EXEC;
        end
      end
      lpmb_pkg::S_EXEC: begin
        state_next      = lpmb_pkg::S_DONE;
        res_status_next = lpmb_pkg::ST_OK;
        res_byte_next   = '0;
        res_last_next   = 1'b0;
        res_mlen_next   = '0;
        if (cmd_r == lpmb_pkg::CMD_NONE) begin
          res_status_next = lpmb_pkg::ST_OK;
        end else if (!arena_bound) begin
          res_status_next = lpmb_pkg::ST_UNBOUND;
        end else begin
          case (cmd_r)
            lpmb_pkg::CMD_PUSH_START: begin
              if (len_r == '0 || len_r > {3'd0, max_len}) begin
                res_status_next = lpmb_pkg::ST_BADLEN;
              end else begin
                res_mlen_next    = len_r[lpmb_pkg::LEN_W-1:0];
                push_active_next = 1'b0;
                if (no_room && read_offset != write_offset) begin
                  dropped_pushes_next = dropped_pushes + 32'd1;
                  res_status_next     = lpmb_pkg::ST_DROPPED;
                end else begin
                  if (no_room) begin
                    write_offset_next = '0;
                    read_offset_next  = '0;
                    pfx_base_next     = '0;
                  end else begin
                    pfx_base_next     = write_offset;
                  end
                  push_active_next    = 1'b1;
                  push_remaining_next = len_r[lpmb_pkg::OFS_W-1:0];
                  push_total_next     = len_r[lpmb_pkg::LEN_W-1:0];
                  push_cursor_next    = (no_room ? '0 : write_offset) +
                                        lpmb_pkg::ofs_t'(lpmb_pkg::PFX_BYTES);
                  cnt_next            = '0;
                  state_next          = lpmb_pkg::S_WR_PFX;
                end
              end
            end
            lpmb_pkg::CMD_PUSH_DATA: begin
              if (!push_active) begin
                res_status_next = lpmb_pkg::ST_DISCARD;
              end else begin
                store_we            = 1'b1;
                store_addr          = push_cursor;
                store_wdata         = byte_r;
                push_cursor_next    = push_cursor_inc;
                push_remaining_next = push_remaining - lpmb_pkg::ofs_t'(1);
                res_mlen_next       = push_total;
                if (push_remaining == lpmb_pkg::ofs_t'(1)) begin
                  write_offset_next = push_cursor_inc;
                  push_active_next  = 1'b0;
                end
              end
            end
            lpmb_pkg::CMD_POP: begin
              if (pop_active) begin
                state_next = lpmb_pkg::S_RD_BYTE;
              end else if (read_offset == write_offset) begin
                res_status_next = lpmb_pkg::ST_EMPTY;
              end else if (read_offset > cap_eff || write_offset > cap_eff ||
                           ({1'b0, read_offset} + 14'(lpmb_pkg::PFX_BYTES)) >
                           {1'b0, write_offset}) begin
                res_status_next = lpmb_pkg::ST_CORRUPT;
              end else begin
                pfx_base_next = read_offset;
                cnt_next      = '0;
                plen_next     = '0;
                state_next    = lpmb_pkg::S_RD_PFX;
              end
            end
            default: begin
              res_status_next = lpmb_pkg::ST_OK;
            end
          endcase
        end
      end
      lpmb_pkg::S_WR_PFX: begin
        store_we   = 1'b1;
        store_addr = pfx_addr;
        case (cnt)
          3'd0:    store_wdata = len_r[7:0];
          3'd1:    store_wdata = len_r[15:8];
          default: store_wdata = 8'd0;
        endcase
        cnt_next = cnt + lpmb_pkg::CNT_W'(1);
        if (cnt == lpmb_pkg::CNT_W'(lpmb_pkg::PFX_BYTES - 1)) begin
          state_next = lpmb_pkg::S_DONE;
        end
      end
      lpmb_pkg::S_RD_PFX: begin
        store_addr = pfx_addr;
        cnt_next   = cnt + lpmb_pkg::CNT_W'(1);
        case (cnt)
          3'd1:    plen_next[7:0]   = store_rdata;
          3'd2:    plen_next[15:8]  = store_rdata;
          3'd3:    plen_next[23:16] = store_rdata;
          3'd4:    plen_next[31:24] = store_rdata;
          default: plen_next        = plen;
        endcase
        if (cnt == lpmb_pkg::CNT_W'(lpmb_pkg::PFX_BYTES)) begin
          state_next = lpmb_pkg::S_POP_CHK;
        end
      end
      lpmb_pkg::S_POP_CHK: begin
        if (plen == '0 || plen > {19'd0, avail}) begin
          res_status_next = lpmb_pkg::ST_CORRUPT;
          state_next      = lpmb_pkg::S_DONE;
        end else begin
          pop_active_next    = 1'b1;
          pop_remaining_next = plen[lpmb_pkg::OFS_W-1:0];
          pop_total_next     = plen[lpmb_pkg::LEN_W-1:0];
          pop_cursor_next    = read_offset + lpmb_pkg::ofs_t'(lpmb_pkg::PFX_BYTES);
          state_next         = lpmb_pkg::S_RD_BYTE;
        end
      end
      lpmb_pkg::S_RD_BYTE: begin
        store_addr = pop_cursor;
        state_next = lpmb_pkg::S_BYTE_WAIT;
      end
      lpmb_pkg::S_BYTE_WAIT: begin
        res_byte_next      = store_rdata;
        res_mlen_next      = pop_total;
        pop_cursor_next    = pop_cursor_inc;
        pop_remaining_next = pop_remaining - lpmb_pkg::ofs_t'(1);
        if (pop_remaining == lpmb_pkg::ofs_t'(1)) begin
          res_last_next    = 1'b1;
          pop_active_next  = 1'b0;
          read_offset_next = pop_cursor_inc;
          if (pop_cursor_inc == write_offset && !push_active) begin
            read_offset_next  = '0;
            write_offset_next = '0;
          end
        end
        state_next = lpmb_pkg::S_DONE;
      end
      lpmb_pkg::S_DONE: begin
        if (!m_tvalid || m_tready) begin
          m_tvalid_next = 1'b1;
          state_next    = lpmb_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = lpmb_pkg::S_IDLE;
      end
    endcase

    if (cfg_we) begin
      if (paddr[2] == lpmb_pkg::REG_CAPACITY) begin
        capacity_next       = pwdata[lpmb_pkg::OFS_W-1:0];
        write_offset_next   = '0;
        read_offset_next    = '0;
        dropped_pushes_next = '0;
        push_active_next    = 1'b0;
        push_remaining_next = '0;
        push_cursor_next    = '0;
        push_total_next     = '0;
        pop_active_next     = 1'b0;
        pop_remaining_next  = '0;
        pop_cursor_next     = '0;
        pop_total_next      = '0;
      end else begin
        arena_bound_next = pwdata[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= lpmb_pkg::S_IDLE;
      m_tvalid       <= 1'b0;
      arena_bound    <= 1'b0;
      capacity       <= lpmb_pkg::CAP_RESET;
      write_offset   <= '0;
      read_offset    <= '0;
      dropped_pushes <= '0;
      push_active    <= 1'b0;
      push_remaining <= '0;
      push_cursor    <= '0;
      push_total     <= '0;
      pop_active     <= 1'b0;
      pop_remaining  <= '0;
      pop_cursor     <= '0;
      pop_total      <= '0;
      cnt            <= '0;
    end else begin
      state          <= state_next;
      m_tvalid       <= m_tvalid_next;
      arena_bound    <= arena_bound_next;
      capacity       <= capacity_next;
      write_offset   <= write_offset_next;
      read_offset    <= read_offset_next;
      dropped_pushes <= dropped_pushes_next;
      push_active    <= push_active_next;
      push_remaining <= push_remaining_next;
      push_cursor    <= push_cursor_next;
      push_total     <= push_total_next;
      pop_active     <= pop_active_next;
      pop_remaining  <= pop_remaining_next;
      pop_cursor     <= pop_cursor_next;
      pop_total      <= pop_total_next;
      cnt            <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      cmd_r  <= lpmb_pkg::cmd_t'(s_tuser);
      len_r  <= s_tdata[15:0];
      byte_r <= s_tdata[23:16];
    end
    pfx_base   <= pfx_base_next;
    plen       <= plen_next;
    res_status <= res_status_next;
    res_byte   <= res_byte_next;
    res_last   <= res_last_next;
    res_mlen   <= res_mlen_next;
    if (state == lpmb_pkg::S_DONE && (!m_tvalid || m_tready)) begin
      out_status <= res_status;
      out_byte   <= res_byte;
      out_last   <= res_last;
      out_mlen   <= res_mlen;
      out_drop   <= dropped_pushes;
    end
  end

  lpmb_store #(
    .DEPTH (STORE_BYTES),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (store_we & store_in_range),
    .addr  (AW'(store_addr)),
    .wdata (store_wdata),
    .rdata (store_rdata)
  );

  // offsets never run past the usable capacity
  a_offsets_in_cap: assert property (@(posedge clk) disable iff (rst)
    write_offset <= cap_eff && read_offset <= cap_eff)
    else $error("queue offset beyond capacity");

  // store writes only from a push data step or the prefix writer
  a_store_we_src: assert property (@(posedge clk) disable iff (rst)
    store_we |-> (state == lpmb_pkg::S_WR_PFX ||
                  (state == lpmb_pkg::S_EXEC && cmd_r == lpmb_pkg::CMD_PUSH_DATA)))
    else $error("store write outside push steps");

  // a result leaving the sequencer lands in the output register
  a_done_loads: assert property (@(posedge clk) disable iff (rst)
    state == lpmb_pkg::S_DONE && (!m_tvalid || m_tready) |=> m_tvalid)
    else $error("result not presented");

  // the final byte of a message is only flagged on a good pop
  a_last_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser == lpmb_pkg::ST_OK)
    else $error("last flag with error status");

  // an open pop always has bytes left
  a_pop_remaining: assert property (@(posedge clk) disable iff (rst)
    pop_active |-> pop_remaining != '0)
    else $error("pop active with nothing remaining");

endmodule

// ===== rtl/lpmb_store.sv =====
// ----------------------------------------------------------------------------
// lpmb_store
// Single-port byte store with registered read data.
// ----------------------------------------------------------------------------
module lpmb_store #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [7:0]    wdata,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== verif/length_prefixed_message_buffer_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefixed_message_buffer_core_test
// Self-checking bench for the byte message queue. A directed opening hits
// unbound access, length limits, abandoned and stray pushes, a drain during
// an open push, restart at offset zero and a refused push. Random message
// traffic then runs over several capacities, including the smallest, zero,
// and an out-of-range value. Every result is checked against a behavioral
// queue model kept in step with each accepted input transfer.
// ----------------------------------------------------------------------------
module length_prefixed_message_buffer_core_test;

  localparam int unsigned STORE_SIZE    = 4096;
  localparam int unsigned CYCLE_LIMIT   = 250000;
  localparam int unsigned LONG_HOLD     = 400;
  localparam int unsigned SETTLE_CYCLES = 16;

  typedef struct {
    lpmb_pkg::cmd_t op;
    logic [15:0]    len;
    logic [7:0]     dbyte;
  } stream_item_t;

  typedef struct {
    lpmb_pkg::status_t          status;
    logic [7:0]                 out_byte;
    logic                       last;
    logic [lpmb_pkg::LEN_W-1:0] msg_len;
    logic [31:0]                drops;
  } reply_t;

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata  = '0;
  logic [1:0]  s_tuser  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;

  length_prefixed_message_buffer_core #(
    .STORE_BYTES(STORE_SIZE)
  ) u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // queue model state
  logic [7:0]  shadow_store [STORE_SIZE];
  int unsigned wr_ofs, rd_ofs;
  logic [31:0] drops_q;
  bit          pushing, popping;
  int unsigned push_left, push_at, push_len;
  int unsigned pop_left, pop_at, pop_len;
  bit          bound_q;
  logic [12:0] cap_q;

  stream_item_t items_to_send [$];
  reply_t       replies_due [$];

  int unsigned src_wait = 0, sink_wait = 0, sink_gap;
  bit          src_calm = 1'b0, sink_calm = 1'b0;
  logic        sink_hold = 1'b0;
  bit          hold_go = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned fail_count = 0;
  int unsigned items_sent = 0, replies_seen = 0;
  int unsigned status_seen [8];
  stream_item_t nxt;
  reply_t       want;

  function automatic void model_clear();
    wr_ofs    = 0;
    rd_ofs    = 0;
    drops_q   = '0;
    pushing   = 1'b0;
    push_left = 0;
    push_at   = 0;
    push_len  = 0;
    popping   = 1'b0;
    pop_left  = 0;
    pop_at    = 0;
    pop_len   = 0;
  endfunction

  function automatic void store_put(input int unsigned addr, input logic [7:0] v);
    if (addr < STORE_SIZE) shadow_store[addr] = v;
  endfunction

  function automatic logic [7:0] store_get(input int unsigned addr);
    return (addr < STORE_SIZE) ? shadow_store[addr] : 8'h00;
  endfunction

  function automatic reply_t compute_reply(input lpmb_pkg::cmd_t op, input logic [15:0] len,
                                           input logic [7:0] dbyte);
    reply_t      r;
    int unsigned eff, maxlen, need, base, plen, i;
    bit          room;
    r.status   = lpmb_pkg::ST_OK;
    r.out_byte = '0;
    r.last     = 1'b0;
    r.msg_len  = '0;
    eff = (cap_q > STORE_SIZE) ? STORE_SIZE : cap_q;
    if (op == lpmb_pkg::CMD_NONE) begin
    end else if (!bound_q) begin
      r.status = lpmb_pkg::ST_UNBOUND;
    end else if (op == lpmb_pkg::CMD_PUSH_START) begin
      maxlen = (eff > lpmb_pkg::PFX_BYTES) ? eff - lpmb_pkg::PFX_BYTES : 0;
      if (len == 0 || len > maxlen) begin
        r.status = lpmb_pkg::ST_BADLEN;
      end else begin
        need      = len + lpmb_pkg::PFX_BYTES;
        base      = wr_ofs;
        room      = 1'b1;
        r.msg_len = len[lpmb_pkg::LEN_W-1:0];
        pushing   = 1'b0;
        if (wr_ofs > eff || rd_ofs > eff || need > eff - wr_ofs) begin
          if (rd_ofs != wr_ofs) begin
            drops_q  = drops_q + 1;
            r.status = lpmb_pkg::ST_DROPPED;
            room     = 1'b0;
          end else begin
            base   = 0;
            wr_ofs = 0;
            rd_ofs = 0;
          end
        end
        if (room) begin
          for (i = 0; i < lpmb_pkg::PFX_BYTES; i++) store_put(base + i, 8'(len >> (8 * i)));
          pushing   = 1'b1;
          push_left = len;
          push_len  = len;
          push_at   = base + lpmb_pkg::PFX_BYTES;
        end
      end
    end else if (op == lpmb_pkg::CMD_PUSH_DATA) begin
      if (!pushing) begin
        r.status = lpmb_pkg::ST_DISCARD;
      end else begin
        store_put(push_at, dbyte);
        push_at   = push_at + 1;
        push_left = push_left - 1;
        r.msg_len = lpmb_pkg::LEN_W'(push_len);
        if (push_left == 0) begin
          wr_ofs  = push_at;
          pushing = 1'b0;
        end
      end
    end else begin
      if (!popping) begin
        if (rd_ofs == wr_ofs) begin
          r.status = lpmb_pkg::ST_EMPTY;
        end else if (rd_ofs > eff || wr_ofs > eff ||
                     rd_ofs + lpmb_pkg::PFX_BYTES > wr_ofs) begin
          r.status = lpmb_pkg::ST_CORRUPT;
        end else begin
          plen = 0;
          for (i = 0; i < lpmb_pkg::PFX_BYTES; i++)
            plen |= int'(store_get(rd_ofs + i)) << (8 * i);
          if (plen == 0 || plen > wr_ofs - rd_ofs - lpmb_pkg::PFX_BYTES) begin
            r.status = lpmb_pkg::ST_CORRUPT;
          end else begin
            popping  = 1'b1;
            pop_left = plen;
            pop_len  = plen;
            pop_at   = rd_ofs + lpmb_pkg::PFX_BYTES;
          end
        end
      end
      if (r.status == lpmb_pkg::ST_OK && popping) begin
        r.out_byte = store_get(pop_at);
        pop_at     = pop_at + 1;
        pop_left   = pop_left - 1;
        r.msg_len  = lpmb_pkg::LEN_W'(pop_len);
        if (pop_left == 0) begin
          r.last  = 1'b1;
          popping = 1'b0;
          rd_ofs  = pop_at;
          if (rd_ofs == wr_ofs && !pushing) begin
            rd_ofs = 0;
            wr_ofs = 0;
          end
        end
      end
    end
    r.drops = drops_q;
    return r;
  endfunction

  function automatic void field_cmp(input string name, input longint unsigned exp_v,
                                    input longint unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  function automatic void add_item(input lpmb_pkg::cmd_t op, input int unsigned len,
                                   input int unsigned dbyte);
    stream_item_t it;
    it.op    = op;
    it.len   = 16'(len);
    it.dbyte = 8'(dbyte);
    items_to_send.insert(items_to_send.size(), it);
  endfunction

  // input side
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      src_wait <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        replies_due.insert(replies_due.size(),
                           compute_reply(lpmb_pkg::cmd_t'(s_tuser), s_tdata[15:0],
                                         s_tdata[23:16]));
        items_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (src_wait != 0) begin
          s_tvalid <= 1'b0;
          src_wait <= src_wait - 1;
        end else if (items_to_send.size() != 0) begin
          nxt = items_to_send.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= nxt.op;
          s_tdata  <= {nxt.dbyte, nxt.len};
          if ($urandom_range(0, 31) == 0) src_calm = !src_calm;
          src_wait <= src_calm ? 0 : $urandom_range(0, 19);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // output side
  always @(posedge clk) begin
    if (rst) begin
      m_tready  <= 1'b0;
      sink_wait <= 0;
    end else begin
      sink_gap = sink_wait;
      if (m_tvalid && m_tready) begin
        replies_seen++;
        status_seen[m_tuser]++;
        if (replies_due.size() == 0) begin
          $display("%0t: unexpected result transfer, expected none, actual status %0d",
                   $time, m_tuser);
          fail_count++;
        end else begin
          want = replies_due.pop_front();
          field_cmp("status", want.status, m_tuser);
          field_cmp("out_byte", want.out_byte, m_tdata[7:0]);
          field_cmp("last_byte", want.last, m_tlast);
          field_cmp("message_length", want.msg_len, m_tdata[19:8]);
          field_cmp("drop_count", want.drops, m_tdata[51:20]);
        end
        if ($urandom_range(0, 31) == 0) sink_calm = !sink_calm;
        sink_gap = sink_calm ? 0 : $urandom_range(0, 19);
      end
      m_tready  <= (sink_gap == 0 && !sink_hold);
      sink_wait <= (sink_gap != 0) ? sink_gap - 1 : 0;
    end
  end

  // long receiver stall
  initial begin
    wait (hold_go);
    @(posedge clk);
    sink_hold <= 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    sink_hold <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic drain_all();
    while (items_to_send.size() != 0 || s_tvalid || replies_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input logic idx, input logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == lpmb_pkg::REG_ARENA_BOUND) begin
      bound_q = val[0];
    end else begin
      cap_q = val[12:0];
      model_clear();
    end
  endtask

  task automatic run_mix(input int unsigned budget);
    int unsigned    made, maxlen, eff, len, n, k;
    lpmb_pkg::cmd_t op;
    eff    = (cap_q > STORE_SIZE) ? STORE_SIZE : cap_q;
    maxlen = (eff > lpmb_pkg::PFX_BYTES) ? eff - lpmb_pkg::PFX_BYTES : 0;
    made   = 0;
    while (made < budget) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          if (maxlen == 0) begin
            len = $urandom_range(0, 65535);
            n   = 0;
          end else begin
            if ($urandom_range(0, 19) == 0)
              len = $urandom_range(1, (maxlen < 300) ? maxlen : 300);
            else
              len = $urandom_range(1, (maxlen < 16) ? maxlen : 16);
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, len) : len;
          end
          add_item(lpmb_pkg::CMD_PUSH_START, len, $urandom_range(0, 255));
          for (k = 0; k < n; k++)
            add_item(lpmb_pkg::CMD_PUSH_DATA, $urandom_range(0, 65535),
                     $urandom_range(0, 255));
          made += n + 1;
        end
        6, 7, 8: begin
          n = $urandom_range(1, 20);
          for (k = 0; k < n; k++)
            add_item(lpmb_pkg::CMD_POP, $urandom_range(0, 65535), $urandom_range(0, 255));
          made += n;
        end
        default: begin
          op = lpmb_pkg::cmd_t'($urandom_range(0, 3));
          add_item(op, $urandom_range(0, 65535), $urandom_range(0, 255));
          if (op != lpmb_pkg::CMD_NONE) made++;
        end
      endcase
    end
    drain_all();
  endtask

  initial begin
    bound_q = 1'b0;
    cap_q   = lpmb_pkg::CAP_RESET;
    model_clear();
    foreach (shadow_store[i]) shadow_store[i] = 8'h00;
    foreach (status_seen[i]) status_seen[i] = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // no arena attached
    add_item(lpmb_pkg::CMD_PUSH_START, 3, 8'h11);
    add_item(lpmb_pkg::CMD_PUSH_DATA, 0, 8'h22);
    add_item(lpmb_pkg::CMD_POP, 0, 0);
    add_item(lpmb_pkg::CMD_NONE, 16'hFFFF, 8'hFF);
    drain_all();

    // length limits, abandoned push, stray byte, empty pop
    reg_write(lpmb_pkg::REG_ARENA_BOUND, 32'd1);
    add_item(lpmb_pkg::CMD_PUSH_START, 0, 8'h00);
    add_item(lpmb_pkg::CMD_PUSH_START, 16'hFFFF, 8'hFF);
    add_item(lpmb_pkg::CMD_PUSH_START, 4093, 0);
    add_item(lpmb_pkg::CMD_PUSH_START, 4092, 0);
    add_item(lpmb_pkg::CMD_PUSH_START, 1, 0);
    add_item(lpmb_pkg::CMD_PUSH_DATA, 16'hFFFF, 8'h00);
    add_item(lpmb_pkg::CMD_PUSH_DATA, 0, 8'hFF);
    add_item(lpmb_pkg::CMD_POP, 0, 0);
    add_item(lpmb_pkg::CMD_POP, 0, 0);
    drain_all();

    // drain during open push, restart at zero, refused push
    reg_write(lpmb_pkg::REG_CAPACITY, 32'd12);
    add_item(lpmb_pkg::CMD_PUSH_START, 3, 0);
    add_item(lpmb_pkg::CMD_PUSH_DATA, 0, 8'hFF);
    add_item(lpmb_pkg::CMD_PUSH_DATA, 0, 8'h00);
    add_item(lpmb_pkg::CMD_PUSH_DATA, 0, 8'hA5);
    add_item(lpmb_pkg::CMD_PUSH_START, 1, 0);
    repeat (3) add_item(lpmb_pkg::CMD_POP, 0, 0);
    add_item(lpmb_pkg::CMD_PUSH_START, 2, 0);
    add_item(lpmb_pkg::CMD_PUSH_DATA, 0, 8'h5A);
    add_item(lpmb_pkg::CMD_PUSH_DATA, 0, 8'hC3);
    repeat (2) add_item(lpmb_pkg::CMD_POP, 0, 0);
    add_item(lpmb_pkg::CMD_PUSH_START, 3, 0);
    repeat (3) add_item(lpmb_pkg::CMD_PUSH_DATA, 0, $urandom_range(0, 255));
    add_item(lpmb_pkg::CMD_PUSH_START, 2, 0);
    repeat (3) add_item(lpmb_pkg::CMD_POP, 0, 0);
    drain_all();

    reg_write(lpmb_pkg::REG_CAPACITY, 32'd64);
    hold_go = 1'b1;
    run_mix(90);
    reg_write(lpmb_pkg::REG_CAPACITY, 32'd5);
    run_mix(40);
    reg_write(lpmb_pkg::REG_CAPACITY, 32'd4);
    run_mix(15);
    reg_write(lpmb_pkg::REG_CAPACITY, 32'd0);
    run_mix(10);
    reg_write(lpmb_pkg::REG_CAPACITY, 32'h1FFF);
    run_mix(70);
    reg_write(lpmb_pkg::REG_ARENA_BOUND, 32'd0);
    run_mix(15);
    reg_write(lpmb_pkg::REG_ARENA_BOUND, 32'd1);
    run_mix(50);
    reg_write(lpmb_pkg::REG_CAPACITY, 32'd4096);
    run_mix(60);
    reg_write(lpmb_pkg::REG_CAPACITY, 32'd40);
    run_mix(60);

    $display("covered %0d input transfers and %0d result transfers in %0d cycles",
             items_sent, replies_seen, cycle_count);
    $display("statuses: ok %0d unbound %0d bad length %0d dropped %0d empty %0d discarded %0d",
             status_seen[lpmb_pkg::ST_OK], status_seen[lpmb_pkg::ST_UNBOUND],
             status_seen[lpmb_pkg::ST_BADLEN], status_seen[lpmb_pkg::ST_DROPPED],
             status_seen[lpmb_pkg::ST_EMPTY], status_seen[lpmb_pkg::ST_DISCARD]);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
